[sv/jse_pkg.sv]
// ----------------------------------------------------------------------------
// jse_pkg: shared types and helpers for the JSON string escaper
// Item structs, the command passed from the classifier to the emitter,
// and small character lookup functions.
// ----------------------------------------------------------------------------
package jse_pkg;

  // Input item kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_UNESCAPED_UNICODE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SIMPLE_MODE       = 2'd1;

  // Command queue depth
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       string_end;
    logic       error;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_INSIDE  = 2'd1,
    PH_SWALLOW = 2'd2
  } phase_e;

  // Output sequences the emitter knows how to produce
  typedef enum logic [2:0] {
    CMD_LIT   = 3'd0,  // one byte
    CMD_ESC   = 3'd1,  // backslash, then one byte
    CMD_U16   = 3'd2,  // \uXXXX of word[15:0]
    CMD_PAIR  = 3'd3,  // \uXXXX of word[31:16], then of word[15:0]
    CMD_RAW   = 3'd4,  // nraw bytes of word, oldest in the top byte
    CMD_ERR   = 3'd5,  // error result
    CMD_CLOSE = 3'd6   // closing quote
  } cmd_e;

  typedef struct packed {
    cmd_e        op;
    logic [31:0] word;
    logic [2:0]  nraw;
  } cmd_t;

  // Lowercase hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'h0, nib};
    end else begin
      c = 8'h57 + {4'h0, nib};
    end
    return c;
  endfunction

  // Short escape letter: {found, letter}
  function automatic logic [8:0] short_escape(input logic [7:0] x);
    logic [8:0] r;
    unique case (x)
      8'h08:   r = {1'b1, 8'h62};
      8'h0C:   r = {1'b1, 8'h66};
      8'h0A:   r = {1'b1, 8'h6E};
      8'h0D:   r = {1'b1, 8'h72};
      8'h09:   r = {1'b1, 8'h74};
      default: r = 9'h000;
    endcase
    return r;
  endfunction

endpackage

[sv/json_string_escaper_utf8_unit.sv]
// Path: an item's command is queued, then emitted through the output register.
// Throughput: one item per cycle if each gives at most one result and output is
// not stalled; the output stage sends one byte per cycle unless stalled, so an
// n-result item holds the emitter; the two-entry queue fills and stalls input.
// Reset: asynchronous, active low; clears phase, pending sequence, queue and mode.
// ----------------------------------------------------------------------------
// json_string_escaper_utf8_unit: JSON string literal escaper with UTF-8 check
// Classifier front end, command queue and byte emitter, plus mode registers.
// ----------------------------------------------------------------------------
module json_string_escaper_utf8_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  jse_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output jse_pkg::out_item_t             out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [jse_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic                           cfg_data_i
);

  logic          unescaped_unicode_q;
  logic          simple_mode_q;
  logic          q_full, q_empty, push, pop;
  jse_pkg::cmd_t push_cmd, head_cmd;

  // Mode registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unescaped_unicode_q <= 1'b0;
      simple_mode_q       <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == jse_pkg::CFG_UNESCAPED_UNICODE) begin
        unescaped_unicode_q <= cfg_data_i;
      end else if (cfg_index_i == jse_pkg::CFG_SIMPLE_MODE) begin
        simple_mode_q <= cfg_data_i;
      end
    end
  end

  jse_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .unescaped_unicode_i (unescaped_unicode_q),
    .simple_mode_i       (simple_mode_q),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .in_data_i           (in_data_i),
    .q_full_i            (q_full),
    .push_o              (push),
    .cmd_o               (push_cmd)
  );

  jse_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head_cmd)
  );

  jse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .head_i      (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[sv/jse_fifo.sv]
// ----------------------------------------------------------------------------
// jse_fifo: command queue between classifier and emitter
// Small register queue; the head is visible without a pop.
// ----------------------------------------------------------------------------
module jse_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jse_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output jse_pkg::cmd_t head_o
);

  jse_pkg::cmd_t             mem_q [jse_pkg::QDepth];
  logic [jse_pkg::QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [jse_pkg::QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [jse_pkg::QPtrW:0]   count_q, count_d;
  logic                      do_push, do_pop;

  assign full_o  = (count_q == (jse_pkg::QPtrW+1)'(jse_pkg::QDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == jse_pkg::QPtrW'(jse_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == jse_pkg::QPtrW'(jse_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[sv/jse_front.sv]
// ----------------------------------------------------------------------------
// jse_front: item classifier
// Tracks string phase and pending UTF-8 sequence, and turns each accepted
// item into at most one emitter command.
// ----------------------------------------------------------------------------
module jse_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             unescaped_unicode_i,
  input  logic             simple_mode_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  jse_pkg::in_item_t in_data_i,
  input  logic             q_full_i,
  output logic             push_o,
  output jse_pkg::cmd_t    cmd_o
);

  jse_pkg::phase_e phase_q, phase_d;
  logic [1:0]      need_q, need_d;
  logic [1:0]      held_q, held_d;
  logic [23:0]     seq_q, seq_d;

  logic        accept;
  logic [7:0]  x;
  logic [8:0]  sesc;
  logic        is_special;
  logic [20:0] cp;
  logic [20:0] cp_off;
  logic        seq_ok;
  logic [31:0] raw_word;
  logic [2:0]  raw_n;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign x          = in_data_i.data_byte;
  assign sesc       = jse_pkg::short_escape(x);
  assign is_special = (x == 8'h22) || (x == 8'h5C) || (x == 8'h2F);
  assign cp_off     = cp - 21'h010000;

  // Decode the sequence completed by this byte
  always_comb begin
    cp       = '0;
    seq_ok   = 1'b0;
    raw_word = '0;
    raw_n    = 3'd0;
    unique case (held_q)
      2'd1: begin
        cp       = {10'h0, seq_q[4:0], x[5:0]};
        seq_ok   = |seq_q[4:1];
        raw_word = {seq_q[7:0], x, 16'h0};
        raw_n    = 3'd2;
      end
      2'd2: begin
        cp       = {5'h0, seq_q[11:8], seq_q[5:0], x[5:0]};
        seq_ok   = ((|seq_q[11:8]) || seq_q[5]) && !(cp >= 21'h00D800 && cp <= 21'h00DFFF);
        raw_word = {seq_q[15:0], x, 8'h0};
        raw_n    = 3'd3;
      end
      2'd3: begin
        cp       = {seq_q[18:16], seq_q[13:8], seq_q[5:0], x[5:0]};
        seq_ok   = ((|seq_q[18:16]) || (|seq_q[13:12])) && (cp <= 21'h10FFFF);
        raw_word = {seq_q[23:0], x};
        raw_n    = 3'd4;
      end
      default: begin
        seq_ok = 1'b0;
      end
    endcase
  end

  // Next state and command
  always_comb begin
    phase_d     = phase_q;
    need_d      = need_q;
    held_d      = held_q;
    seq_d       = seq_q;
    push_o      = 1'b0;
    cmd_o.op    = jse_pkg::CMD_LIT;
    cmd_o.word  = '0;
    cmd_o.nraw  = 3'd0;
    if (accept) begin
      unique case (in_data_i.kind)
        jse_pkg::KIND_START: begin
          need_d     = '0;
          held_d     = '0;
          seq_d      = '0;
          phase_d    = jse_pkg::PH_INSIDE;
          push_o     = 1'b1;
          cmd_o.op   = jse_pkg::CMD_LIT;
          cmd_o.word = 32'h22;
        end
        jse_pkg::KIND_DATA: begin
          if (phase_q == jse_pkg::PH_INSIDE) begin
            if (simple_mode_i) begin
              need_d = '0;
              held_d = '0;
              seq_d  = '0;
              if (x < 8'h20) begin
                push_o     = sesc[8];
                cmd_o.op   = jse_pkg::CMD_ESC;
                cmd_o.word = {24'h0, sesc[7:0]};
              end else begin
                push_o     = 1'b1;
                cmd_o.op   = is_special ? jse_pkg::CMD_ESC : jse_pkg::CMD_LIT;
                cmd_o.word = {24'h0, x};
              end
            end else if (need_q != 2'd0) begin
              if (x[7:6] != 2'b10) begin
                // bad continuation byte
                push_o   = 1'b1;
                cmd_o.op = jse_pkg::CMD_ERR;
                phase_d  = jse_pkg::PH_SWALLOW;
                need_d   = '0;
                held_d   = '0;
                seq_d    = '0;
              end else if (need_q > 2'd1) begin
                seq_d  = {seq_q[15:0], x};
                held_d = held_q + 1'b1;
                need_d = need_q - 1'b1;
              end else begin
                need_d = '0;
                held_d = '0;
                seq_d  = '0;
                push_o = 1'b1;
                if (!seq_ok) begin
                  cmd_o.op = jse_pkg::CMD_ERR;
                  phase_d  = jse_pkg::PH_SWALLOW;
                end else if (unescaped_unicode_i) begin
                  cmd_o.op   = jse_pkg::CMD_RAW;
                  cmd_o.word = raw_word;
                  cmd_o.nraw = raw_n;
                end else if (cp < 21'h010000) begin
                  cmd_o.op   = jse_pkg::CMD_U16;
                  cmd_o.word = {16'h0, cp[15:0]};
                end else begin
                  cmd_o.op   = jse_pkg::CMD_PAIR;
                  cmd_o.word = {6'b110110, cp_off[19:10], 6'b110111, cp_off[9:0]};
                end
              end
            end else if (x[7]) begin
              if (!x[6] || x >= 8'hF8) begin
                // bare continuation or invalid lead
                push_o   = 1'b1;
                cmd_o.op = jse_pkg::CMD_ERR;
                phase_d  = jse_pkg::PH_SWALLOW;
                need_d   = '0;
                held_d   = '0;
                seq_d    = '0;
              end else begin
                need_d = (x < 8'hE0) ? 2'd1 : ((x < 8'hF0) ? 2'd2 : 2'd3);
                held_d = 2'd1;
                seq_d  = {16'h0, x};
              end
            end else if (is_special) begin
              push_o     = 1'b1;
              cmd_o.op   = jse_pkg::CMD_ESC;
              cmd_o.word = {24'h0, x};
            end else if (x < 8'h20) begin
              push_o = 1'b1;
              if (sesc[8]) begin
                cmd_o.op   = jse_pkg::CMD_ESC;
                cmd_o.word = {24'h0, sesc[7:0]};
              end else begin
                cmd_o.op   = jse_pkg::CMD_U16;
                cmd_o.word = {24'h0, x};
              end
            end else begin
              push_o     = 1'b1;
              cmd_o.op   = jse_pkg::CMD_LIT;
              cmd_o.word = {24'h0, x};
            end
          end
        end
        jse_pkg::KIND_END: begin
          if (phase_q == jse_pkg::PH_INSIDE) begin
            push_o   = 1'b1;
            cmd_o.op = (!simple_mode_i && need_q != 2'd0) ? jse_pkg::CMD_ERR
                                                           : jse_pkg::CMD_CLOSE;
            need_d   = '0;
            held_d   = '0;
            seq_d    = '0;
            phase_d  = jse_pkg::PH_IDLE;
          end else if (phase_q == jse_pkg::PH_SWALLOW) begin
            phase_d = jse_pkg::PH_IDLE;
          end
        end
        default: begin
          // unused kind: drop
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= jse_pkg::PH_IDLE;
      need_q  <= '0;
      held_q  <= '0;
      seq_q   <= '0;
    end else begin
      phase_q <= phase_d;
      need_q  <= need_d;
      held_q  <= held_d;
      seq_q   <= seq_d;
    end
  end

endmodule

[sv/jse_back.sv]
// ----------------------------------------------------------------------------
// jse_back: byte emitter
// Expands the command at the queue head into output bytes, one per cycle
// while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module jse_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  jse_pkg::cmd_t      head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output jse_pkg::out_item_t out_data_o
);

  logic [3:0]         idx_q, idx_d;
  logic               out_valid_q, out_valid_d;
  jse_pkg::out_item_t out_q;
  jse_pkg::out_item_t cur;
  logic               load;
  logic [3:0]         len;
  logic               second;
  logic [15:0]        unit;
  logic [3:0]         pos;
  logic [3:0]         nib;
  logic [7:0]         hex_byte;
  logic [7:0]         raw_byte;

  assign second = (head_i.op == jse_pkg::CMD_PAIR) && (idx_q >= 4'd6);
  assign unit   = (head_i.op == jse_pkg::CMD_PAIR && !second) ? head_i.word[31:16]
                                                              : head_i.word[15:0];
  assign pos    = second ? idx_q - 4'd6 : idx_q;

  // Pick the hex nibble and the raw byte for this position
  always_comb begin
    unique case (pos[2:0])
      3'd2:    nib = unit[15:12];
      3'd3:    nib = unit[11:8];
      3'd4:    nib = unit[7:4];
      default: nib = unit[3:0];
    endcase
    unique case (idx_q[1:0])
      2'd0:    raw_byte = head_i.word[31:24];
      2'd1:    raw_byte = head_i.word[23:16];
      2'd2:    raw_byte = head_i.word[15:8];
      default: raw_byte = head_i.word[7:0];
    endcase
  end

  always_comb begin
    if (pos == 4'd0) begin
      hex_byte = 8'h5C;
    end else if (pos == 4'd1) begin
      hex_byte = 8'h75;
    end else begin
      hex_byte = jse_pkg::hex_char(nib);
    end
  end

  // Form the current output byte and the command length
  always_comb begin
    cur = '0;
    len = 4'd1;
    unique case (head_i.op)
      jse_pkg::CMD_LIT: begin
        cur.out_byte = head_i.word[7:0];
      end
      jse_pkg::CMD_ESC: begin
        len          = 4'd2;
        cur.out_byte = (idx_q == 4'd0) ? 8'h5C : head_i.word[7:0];
      end
      jse_pkg::CMD_U16: begin
        len          = 4'd6;
        cur.out_byte = hex_byte;
      end
      jse_pkg::CMD_PAIR: begin
        len          = 4'd12;
        cur.out_byte = hex_byte;
      end
      jse_pkg::CMD_RAW: begin
        len          = {1'b0, head_i.nraw};
        cur.out_byte = raw_byte;
      end
      jse_pkg::CMD_ERR: begin
        cur.string_end = 1'b1;
        cur.error      = 1'b1;
      end
      jse_pkg::CMD_CLOSE: begin
        cur.out_byte   = 8'h22;
        cur.string_end = 1'b1;
      end
      default: begin
        cur = '0;
      end
    endcase
    cur.last_of_run = (idx_q == len - 4'd1);
  end

  // Advance the output stage
  assign load  = !q_empty_i && (!out_valid_q || out_ready_i);
  assign pop_o = load && cur.last_of_run;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
      idx_d       = cur.last_of_run ? 4'd0 : idx_q + 4'd1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= cur;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[sv/jse_checker.sv]
// ----------------------------------------------------------------------------
// jse_checker: port-level checks for the JSON string escaper
// Watches the result channel and attaches to the top level by bind.
// ----------------------------------------------------------------------------
module jse_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input jse_pkg::out_item_t out_data_o
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Error result is a zero byte that ends the string and the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.error |->
      out_data_o.string_end && out_data_o.last_of_run && out_data_o.out_byte == 8'h00)
    else $error("malformed error result");

  // String end always closes the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.string_end |-> out_data_o.last_of_run)
    else $error("string end not last of run");

  // Normal string end is the closing quote
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.string_end && !out_data_o.error |->
      out_data_o.out_byte == 8'h22)
    else $error("string end is not a quote");

endmodule

bind json_string_escaper_utf8_unit jse_checker u_jse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
